// ----- hdl/analog_out_of_range_event_detector_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the analog out-of-range event detector
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ANALOG_OUT_OF_RANGE_EVENT_DETECTOR_UNIT_ASSERT_SVH
`define ANALOG_OUT_OF_RANGE_EVENT_DETECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AOORED_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AOORED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/aoored_pkg.sv -----
// ----------------------------------------------------------------------------
// aoored_pkg
// Types, register map and constants of the analog out-of-range detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aoored_pkg;

    // Event states.
    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_HIGH   = 2'd1,
        ST_LOW    = 2'd2
    } t_event_state;

    // Notification kinds.
    localparam logic [1:0] KIND_ALARM = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_HI_LIM      = 3'd0;
    localparam logic [2:0] REG_LO_LIM      = 3'd1;
    localparam logic [2:0] REG_DEADBAND    = 3'd2;
    localparam logic [2:0] REG_LIM_EN      = 3'd3;
    localparam logic [2:0] REG_EVT_EN      = 3'd4;
    localparam logic [2:0] REG_DWELL       = 3'd5;
    localparam logic [2:0] REG_NOTIFY_KIND = 3'd6;
    localparam logic [2:0] REG_OOS         = 3'd7;

    localparam int ADDR_W = 5;

    // Reset values: 100.0 and 1.0 in Q16.16.
    localparam logic signed [31:0] HI_LIM_RST   = 32'sd6553600;
    localparam logic signed [31:0] LO_LIM_RST   = 32'sd0;
    localparam logic [30:0]        DEADBAND_RST = 31'd65536;

    // Event enable bits.
    localparam int EE_OFFNORMAL = 0;
    localparam int EE_NORMAL    = 2;

    // Configuration register set.
    typedef struct packed {
        logic signed [31:0] hi_lim;
        logic signed [31:0] lo_lim;
        logic [30:0]        deadband;
        logic [1:0]         lim_en;
        logic [2:0]         evt_en;
        logic [15:0]        dwell;
        logic               notify_kind_cfg;
        logic               oos;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic               notify;
        logic [1:0]         notify_kind;
        logic [1:0]         from_state;
        logic [1:0]         to_state;
        logic signed [31:0] exceeded_limit;
        logic signed [31:0] exceeding_value;
        logic               in_alarm;
        logic               oos_flag;
    } t_result;

endpackage

// ----- hdl/aoored_eval.sv -----
// ----------------------------------------------------------------------------
// aoored_eval
// Single-tick evaluation: limit compare, delay countdown, state update and
// notification gating for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aoored_eval
    import aoored_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_event_state       i_event_state,
    input  logic [15:0]        i_delay,
    input  logic signed [31:0] i_sample,
    input  logic               i_ack_request,
    input  logic [1:0]         i_ack_state,
    output t_event_state       o_event_state,
    output logic [15:0]        o_delay,
    output t_result            o_result
);

    logic               hi_en;
    logic               lo_en;
    logic signed [32:0] sample_x;
    logic signed [32:0] high_ret;
    logic signed [32:0] low_ret;
    logic               cond;
    t_event_state       target;

    assign hi_en    = i_cfg.lim_en[1];
    assign lo_en    = i_cfg.lim_en[0];
    assign sample_x = {i_sample[31], i_sample};

    // Return thresholds with the deadband applied, one bit wider.
    assign high_ret = {i_cfg.hi_lim[31], i_cfg.hi_lim}
                      - $signed({2'b00, i_cfg.deadband});
    assign low_ret  = {i_cfg.lo_lim[31], i_cfg.lo_lim}
                      + $signed({2'b00, i_cfg.deadband});

    // Condition that heads away from the present state.
    always_comb begin
        cond   = 1'b0;
        target = ST_NORMAL;
        case (i_event_state)
            ST_NORMAL: begin
                if (i_sample > i_cfg.hi_lim && hi_en
                    && i_cfg.evt_en[EE_OFFNORMAL]) begin
                    cond   = 1'b1;
                    target = ST_HIGH;
                end else if (i_sample < i_cfg.lo_lim && lo_en) begin
                    cond   = 1'b1;
                    target = ST_LOW;
                end
            end
            ST_HIGH: begin
                cond = (sample_x < high_ret) && hi_en;
            end
            default: begin
                cond = (sample_x > low_ret) && lo_en;
            end
        endcase
    end

    // State update and notification.
    always_comb begin
        o_event_state            = i_event_state;
        o_delay                  = i_delay;
        o_result.notify          = 1'b0;
        o_result.notify_kind     = KIND_ALARM;
        o_result.from_state      = i_event_state;
        o_result.to_state        = i_event_state;
        o_result.exceeded_limit  = '0;
        o_result.exceeding_value = '0;

        if (i_cfg.lim_en == 2'b00) begin
            o_event_state     = ST_NORMAL;
            o_result.to_state = ST_NORMAL;
        end else if (i_ack_request) begin
            o_result.notify      = 1'b1;
            o_result.notify_kind = KIND_ACK;
            o_result.to_state    = i_ack_state;
        end else begin
            // The countdown fires at zero, otherwise it steps down.
            if (cond) begin
                if (i_delay == 16'd0) begin
                    o_event_state = target;
                end else begin
                    o_delay = i_delay - 16'd1;
                end
            end else begin
                o_delay = i_cfg.dwell;
            end
            o_result.to_state = o_event_state;

            if (o_event_state != i_event_state) begin
                if (o_event_state == ST_HIGH && i_cfg.evt_en[EE_OFFNORMAL]) begin
                    o_result.notify         = 1'b1;
                    o_result.exceeded_limit = i_cfg.hi_lim;
                end else if (o_event_state == ST_LOW
                             && i_cfg.evt_en[EE_OFFNORMAL]) begin
                    o_result.notify         = 1'b1;
                    o_result.exceeded_limit = i_cfg.lo_lim;
                end else if (o_event_state == ST_NORMAL
                             && i_cfg.evt_en[EE_NORMAL]) begin
                    o_result.notify         = 1'b1;
                    o_result.exceeded_limit = (i_event_state == ST_HIGH)
                                              ? i_cfg.hi_lim : i_cfg.lo_lim;
                end
                if (o_result.notify) begin
                    o_result.notify_kind     = {1'b0, i_cfg.notify_kind_cfg};
                    o_result.exceeding_value = i_sample;
                end
            end
        end

        o_result.in_alarm = (o_event_state != ST_NORMAL);
        o_result.oos_flag = i_cfg.oos;
    end

endmodule

// ----- hdl/analog_out_of_range_event_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Analog out-of-range event detector
// Each input beat is one evaluation tick for a Q16.16 sample; each tick
// returns exactly one result beat with the notification and event state.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock while the result side is not stalled
// and returns one result beat per input beat, in order. A beat is captured
// in an input register, evaluated as it moves into the result register, and
// is offered on the master side from then on. The sustained rate of one
// beat per cycle is set by the event state and delay counter, which are
// updated in the same cycle that a beat is evaluated. Configuration is
// written through the APB port at byte address 4*i for register i and
// should only change while no beat is in flight.
`timescale 1ns / 1ps

module analog_out_of_range_event_detector_unit
    import aoored_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Sample stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] sample_value, [33:32] ack_state, [39:34] zero
    input  logic [39:0]        s_axis_tdata,
    // [0] ack_request
    input  logic [0:0]         s_axis_tuser,

    // Result stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [1:0] from_state, [3:2] to_state, [35:4] exceeded_limit,
    // [67:36] exceeding_value, [68] in_alarm, [69] oos_flag, [71:70] zero
    output logic [71:0]        m_axis_tdata,
    // [0] notify, [2:1] notify_kind
    output logic [2:0]         m_axis_tuser,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic               r_in_valid;
    logic signed [31:0] r_in_sample;
    logic               r_in_ack;
    logic [1:0]         r_in_ack_state;
    logic               r_out_valid;
    t_result            r_out;
    t_event_state       r_event_state;
    t_event_state       n_event_state;
    logic [15:0]        r_delay;
    logic [15:0]        n_delay;
    t_result            n_out;
    logic               advance;
    logic               cfg_wr;
    logic [2:0]         reg_idx;

    // Pipeline handshake: a beat moves on when the result register frees up.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;

    // Configuration decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_HI_LIM:      n_cfg.hi_lim          = pwdata;
                REG_LO_LIM:      n_cfg.lo_lim          = pwdata;
                REG_DEADBAND:    n_cfg.deadband        = pwdata[30:0];
                REG_LIM_EN:      n_cfg.lim_en          = pwdata[1:0];
                REG_EVT_EN:      n_cfg.evt_en          = pwdata[2:0];
                REG_DWELL:       n_cfg.dwell           = pwdata[15:0];
                REG_NOTIFY_KIND: n_cfg.notify_kind_cfg = pwdata[0];
                REG_OOS:         n_cfg.oos             = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_HI_LIM:      prdata = r_cfg.hi_lim;
            REG_LO_LIM:      prdata = r_cfg.lo_lim;
            REG_DEADBAND:    prdata = {1'b0, r_cfg.deadband};
            REG_LIM_EN:      prdata = {30'd0, r_cfg.lim_en};
            REG_EVT_EN:      prdata = {29'd0, r_cfg.evt_en};
            REG_DWELL:       prdata = {16'd0, r_cfg.dwell};
            REG_NOTIFY_KIND: prdata = {31'd0, r_cfg.notify_kind_cfg};
            REG_OOS:         prdata = {31'd0, r_cfg.oos};
            default:         prdata = '0;
        endcase
    end

    // Evaluation of the beat held in the input register.
    aoored_eval u_eval (
        .i_cfg         (r_cfg),
        .i_event_state (r_event_state),
        .i_delay       (r_delay),
        .i_sample      (r_in_sample),
        .i_ack_request (r_in_ack),
        .i_ack_state   (r_in_ack_state),
        .o_event_state (n_event_state),
        .o_delay       (n_delay),
        .o_result      (n_out)
    );

    // Control state, configuration and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hi_lim          <= HI_LIM_RST;
            r_cfg.lo_lim          <= LO_LIM_RST;
            r_cfg.deadband        <= DEADBAND_RST;
            r_cfg.lim_en          <= '0;
            r_cfg.evt_en          <= '0;
            r_cfg.dwell           <= '0;
            r_cfg.notify_kind_cfg <= 1'b0;
            r_cfg.oos             <= 1'b0;
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_event_state         <= ST_NORMAL;
            r_delay               <= '0;
        end else begin
            r_cfg <= n_cfg;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_event_state <= n_event_state;
                r_delay       <= n_delay;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample    <= s_axis_tdata[31:0];
            r_in_ack_state <= s_axis_tdata[33:32];
            r_in_ack       <= s_axis_tuser[0];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Result beat packing.
    assign m_axis_tdata = {2'b00, r_out.oos_flag, r_out.in_alarm,
                           r_out.exceeding_value, r_out.exceeded_limit,
                           r_out.to_state, r_out.from_state};
    assign m_axis_tuser = {r_out.notify_kind, r_out.notify};

    // Checks.
`include "analog_out_of_range_event_detector_unit_assert.svh"

    `AOORED_ASSERT_SAME(a_no_overwrite, r_out_valid && !m_axis_tready, !advance, "result overwritten while stalled")
    `AOORED_ASSERT_NEXT(a_alarm_matches_state, advance, m_axis_tdata[68] == (r_event_state != ST_NORMAL), "in_alarm disagrees with event state")
    `AOORED_ASSERT_NEXT(a_disabled_silent, advance && r_cfg.lim_en == 2'b00, !m_axis_tuser[0] && r_event_state == ST_NORMAL, "notification with limits disabled")
    `AOORED_ASSERT_NEXT(a_ack_keeps_state, advance && r_in_ack && r_cfg.lim_en != 2'b00, $stable(r_event_state) && m_axis_tuser[2:1] == KIND_ACK, "acknowledge changed the event state")

endmodule
